@@ hdl/ntm_pkg.sv @@
// ============================================================================
// ntm_pkg
// Shared types, register map and constants of the neighbourhood trust map.
// ============================================================================
package ntm_pkg;

  // Sizes fixed by the field definitions
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIXEL_BITS    = 16;
  localparam int TRUST_BITS    = 16;
  localparam int FW_BITS       = 11;
  localparam int FH_BITS       = 13;
  localparam int KAPPA_BITS    = 16;
  localparam int NR_BITS       = 45;
  localparam int NR_SPLIT      = 23;
  localparam int ROW_W         = 12;
  localparam int MAX_HEIGHT    = 4096;
  localparam int REG_DATA_W    = 64;
  localparam int ADDR_W        = 5;

  // One in Q1.15
  localparam logic [PIXEL_BITS-1:0] ONE_Q15 = 16'h8000;

  // Register reset values
  localparam logic [FW_BITS-1:0]    FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [FH_BITS-1:0]    FRAME_HEIGHT_RST = 13'd1024;
  localparam logic [KAPPA_BITS-1:0] KAPPA_RST        = 16'd4096;
  localparam logic [NR_BITS-1:0]    NORM_RECIP_RST   = 45'd536870912;

  // Request operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Register index (paddr bits above the 8-byte slot)
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_KAPPA        = 2'd2,
    REG_NORM_RECIP   = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_TERM,
    S_MUL_LO,
    S_MUL_HI,
    S_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                  operation;
    logic [PIXEL_BITS-1:0] pixel;
  } sample_t;

  typedef struct packed {
    logic [TRUST_BITS-1:0] trust_value;
    logic                  frame_last;
  } result_t;

endpackage

@@ hdl/neighbourhood_trust_map.sv @@
// ============================================================================
// neighbourhood_trust_map
// Per-pixel trust from the Huber consistency of a 3x3 neighbourhood.
// ============================================================================
// Usage:
//   sample channel (sample_valid / sample_stall / sample): pixel requests in
//   raster order, or flush requests that drain one pending result each.
//   result channel (result_valid / result_stall / result): trust per pixel in
//   raster order, frame_width+1 pixel requests behind the input.
//   APB port: frame_width @0x00, frame_height @0x08, kappa @0x10,
//   norm_recip @0x18; write only while no request is in flight.
// Steps from S_IDLE, one request at a time through the sequencer:
//   pixel with no result yet     : S_SHIFT
//   pixel answering a border     : S_SHIFT, S_OUT; flush: S_OUT if pending
//   pixel answering an inner pixel: S_SHIFT; the 8 Huber terms go one per
//     cycle in S_TERM through one 16x17 multiplier, then the 34x23 scaling
//     multiplier runs twice (low, high half of norm_recip); S_FIN, S_OUT.
//   The line memory is read at the edge that takes a pixel and written
//   back in the next cycle (S_SHIFT), so accesses never overlap.
// Reset clears counters, window and output valid; the line memory is left
//   as is. A stalled result holds in the output register while the next
//   request is already taken; the sequencer waits only when a second result
//   is ready before the first has left.
// ============================================================================
module neighbourhood_trust_map
  import ntm_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [REG_DATA_W-1:0] pwdata,
  output logic [REG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);
  localparam int CMP_W  = (PEND_W > FW_BITS) ? PEND_W : FW_BITS;
  localparam int DIFF_W = PIXEL_BITS + 1;
  localparam int TERM_W = PIXEL_BITS + DIFF_W;
  localparam int SUM_W  = 34;
  localparam int MUL_W  = SUM_W + NR_SPLIT;
  localparam int Q_W    = MUL_W - 24;
  localparam logic [2:0] LAST_TERM = 3'd7;

  // Configuration registers
  logic [FW_BITS-1:0]    frame_width;
  logic [FH_BITS-1:0]    frame_height;
  logic [KAPPA_BITS-1:0] kappa;
  logic [NR_BITS-1:0]    norm_recip;
  reg_idx_t              reg_idx;

  // Sequencer and counters
  state_t                state, state_next;
  logic [COL_W-1:0]      col_count;
  logic [ROW_W-1:0]      row_count;
  logic [PEND_W-1:0]     pending;
  logic [COL_W-1:0]      emit_col;
  logic [ROW_W-1:0]      emit_row;
  logic [2:0]            term_idx;

  // Datapath
  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] rd_q;
  logic [PIXEL_BITS-1:0]   win [9];
  logic [PIXEL_BITS-1:0]   pix_q;
  logic [SUM_W-1:0]        sum;
  logic [MUL_W-1:0]        prod_lo;
  logic [MUL_W-1:0]        prod_hi;
  logic [TRUST_BITS-1:0]   res_trust;
  logic                    res_last;

  logic                  accept;
  logic                  load_out;
  logic [CMP_W-1:0]      fw_ext, eff_w;
  logic [FH_BITS-1:0]    eff_h;
  logic [COL_W-1:0]      col_idx;
  logic [ROW_W-1:0]      row_idx;
  logic                  col_wrap, row_wrap;
  logic                  pend_full;
  logic                  emit_border, emit_last, emit_col_wrap, emit_row_wrap;
  logic [PIXEL_BITS-1:0] pix_clamped;
  logic [3:0]            nb_sel;
  logic [PIXEL_BITS-1:0] centre, nb, diff;
  logic                  quad;
  logic [PIXEL_BITS-1:0] mul_a;
  logic [DIFF_W-1:0]     mul_b;
  logic [TERM_W-1:0]     term;
  logic [NR_SPLIT-1:0]   scale_op;
  logic [MUL_W-1:0]      scale_prod;
  logic [MUL_W-1:0]      q_sum;
  logic [Q_W-1:0]        q;

  // APB: always ready, decode on the 8-byte slot
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      kappa        <= KAPPA_RST;
      norm_recip   <= NORM_RECIP_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_BITS-1:0];
        REG_KAPPA:        kappa        <= pwdata[KAPPA_BITS-1:0];
        REG_NORM_RECIP:   norm_recip   <= pwdata[NR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = REG_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = REG_DATA_W'(frame_height);
      REG_KAPPA:        prdata = REG_DATA_W'(kappa);
      REG_NORM_RECIP:   prdata = REG_DATA_W'(norm_recip);
      default:          prdata = '0;
    endcase
  end

  // Effective frame size: zero means one, oversize is clipped
  assign fw_ext = CMP_W'(frame_width);
  always_comb begin
    if (fw_ext == '0)
      eff_w = CMP_W'(1);
    else if (fw_ext > CMP_W'(MAX_WIDTH))
      eff_w = CMP_W'(MAX_WIDTH);
    else
      eff_w = fw_ext;
    if (frame_height == '0)
      eff_h = FH_BITS'(1);
    else if (frame_height > FH_BITS'(MAX_HEIGHT))
      eff_h = FH_BITS'(MAX_HEIGHT);
    else
      eff_h = frame_height;
  end

  // Input position, wrapped at the current frame size
  assign col_idx  = (CMP_W'(col_count) >= eff_w) ? '0 : col_count;
  assign row_idx  = (FH_BITS'(row_count) >= eff_h) ? '0 : row_count;
  assign col_wrap = (CMP_W'(col_idx) + CMP_W'(1)) >= eff_w;
  assign row_wrap = (FH_BITS'(row_idx) + FH_BITS'(1)) >= eff_h;

  // Oldest pending pixel: border, last-of-frame and wrap flags
  assign pend_full     = ((CMP_W+1)'(pending)) >= ((CMP_W+1)'(eff_w) + (CMP_W+1)'(1));
  assign emit_col_wrap = (CMP_W'(emit_col) + CMP_W'(1)) >= eff_w;
  assign emit_row_wrap = (FH_BITS'(emit_row) + FH_BITS'(1)) >= eff_h;
  assign emit_border   = (emit_row == '0) || (emit_col == '0) ||
                         emit_row_wrap || emit_col_wrap;
  assign emit_last     = ((FH_BITS'(emit_row) + FH_BITS'(1)) == eff_h) &&
                         ((CMP_W'(emit_col) + CMP_W'(1)) == eff_w);

  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign load_out     = (state == S_OUT) && (!result_valid || !result_stall);
  assign pix_clamped  = (sample.pixel > ONE_Q15) ? ONE_Q15 : sample.pixel;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sample.operation == OP_FLUSH)
            state_next = (pending != '0) ? S_OUT : S_IDLE;
          else
            state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (pend_full)
          state_next = emit_border ? S_OUT : S_TERM;
        else
          state_next = S_IDLE;
      end
      S_TERM:   state_next = (term_idx == LAST_TERM) ? S_MUL_LO : S_TERM;
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_FIN;
      S_FIN:    state_next = S_OUT;
      S_OUT:    state_next = load_out ? S_IDLE : S_OUT;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Line memory: read on a pixel request, write back the shifted column
  always_ff @(posedge clk) begin
    if (accept && sample.operation == OP_PIXEL)
      rd_q <= line_mem[col_idx];
    if (state == S_SHIFT)
      line_mem[col_idx] <= {rd_q[PIXEL_BITS-1:0], pix_q};
  end

  // Huber term of one neighbour: d*d below kappa, kappa*(2d-kappa) above
  assign nb_sel = (term_idx >= 3'd4) ? 4'(term_idx) + 4'd1 : 4'(term_idx);
  assign centre = win[4];
  assign nb     = win[nb_sel];
  assign diff   = (centre > nb) ? centre - nb : nb - centre;
  assign quad   = diff < kappa;
  assign mul_a  = quad ? diff : kappa;
  assign mul_b  = quad ? DIFF_W'(diff)
                       : ({diff, 1'b0} - DIFF_W'(kappa));
  assign term   = mul_a * mul_b;

  // Scaling multiplier, shared by both halves of norm_recip
  assign scale_op   = (state == S_MUL_LO) ? norm_recip[NR_SPLIT-1:0]
                                          : NR_SPLIT'(norm_recip[NR_BITS-1:NR_SPLIT]);
  assign scale_prod = sum * scale_op;
  assign q_sum      = prod_hi + (prod_lo >> NR_SPLIT);
  assign q          = q_sum[MUL_W-1:24];

  // Counters and window
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      pending   <= '0;
      emit_col  <= '0;
      emit_row  <= '0;
      term_idx  <= '0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else begin
      // Drain one pending result on a flush
      if (accept && sample.operation == OP_FLUSH && pending != '0) begin
        pending <= pending - PEND_W'(1);
        if (emit_col_wrap) begin
          emit_col <= '0;
          emit_row <= emit_row_wrap ? '0 : emit_row + ROW_W'(1);
        end else begin
          emit_col <= emit_col + COL_W'(1);
        end
      end
      if (state == S_SHIFT) begin
        for (int r = 0; r < 3; r++) begin
          win[r*3]   <= win[r*3+1];
          win[r*3+1] <= win[r*3+2];
        end
        win[2] <= rd_q[2*PIXEL_BITS-1:PIXEL_BITS];
        win[5] <= rd_q[PIXEL_BITS-1:0];
        win[8] <= pix_q;
        // Advance input position
        if (col_wrap) begin
          col_count <= '0;
          row_count <= row_wrap ? '0 : row_idx + ROW_W'(1);
        end else begin
          col_count <= col_idx + COL_W'(1);
          row_count <= row_idx;
        end
        // Answer the oldest pixel once the pipe holds a line plus one
        if (pend_full) begin
          if (emit_col_wrap) begin
            emit_col <= '0;
            emit_row <= emit_row_wrap ? '0 : emit_row + ROW_W'(1);
          end else begin
            emit_col <= emit_col + COL_W'(1);
          end
        end else begin
          pending <= pending + PEND_W'(1);
        end
        term_idx <= '0;
      end
      if (state == S_TERM)
        term_idx <= term_idx + 3'd1;
    end
  end

  // Payload path
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_q     <= pix_clamped;
      res_trust <= ONE_Q15;
      res_last  <= emit_last;
    end
    case (state)
      S_SHIFT: begin
        sum      <= '0;
        res_last <= emit_last;
      end
      S_TERM:   sum     <= sum + SUM_W'(term);
      S_MUL_LO: prod_lo <= scale_prod;
      S_MUL_HI: prod_hi <= scale_prod;
      S_FIN: begin
        if (q >= Q_W'(ONE_Q15))
          res_trust <= '0;
        else
          res_trust <= ONE_Q15 - q[TRUST_BITS-1:0];
      end
      default: ;
    endcase
  end

  // Output register: load when empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.trust_value <= res_trust;
      result.frame_last  <= res_last;
    end
  end

endmodule

@@ hdl/ntm_checker.sv @@
// ============================================================================
// ntm_checker
// Port-level checks of the neighbourhood trust map, bound to the top level.
// ============================================================================
module ntm_checker
  import ntm_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input sample_t sample,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Trust never above one
  a_trust_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.trust_value <= ONE_Q15)
    else $error("trust above 1.0");

  // A pixel request keeps the sequencer busy for the next cycle
  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && sample.operation == OP_PIXEL |=> sample_stall)
    else $error("request taken while pixel in progress");

endmodule

bind neighbourhood_trust_map ntm_checker u_ntm_checker (.*);
